// File: rtl/core/mdd_pkg.sv
// ----------------------------------------------------------------------------
// mdd_pkg
// shared widths, sequencer states and divider status for the drawdown tracker
// ----------------------------------------------------------------------------
package mdd_pkg;

  localparam int PRICE_BITS = 32;
  localparam int INDEX_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DD_BITS    = FRAC_BITS + 1;
  localparam int CNT_BITS   = $clog2(FRAC_BITS + 1);

  localparam logic [DD_BITS-1:0]    DD_ONE    = DD_BITS'(1) << FRAC_BITS;
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_DIV,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/core/mdd_div.sv
// ----------------------------------------------------------------------------
// mdd_div
// shared restoring divider: (peak - price) / peak as a Q1.16 fraction,
// one quotient bit per cycle through a single compare and subtract
// ----------------------------------------------------------------------------
module mdd_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [mdd_pkg::PRICE_BITS-1:0]   peak,
  input  logic [mdd_pkg::PRICE_BITS-1:0]   price,
  output mdd_pkg::div_stat_t               stat,
  output logic [mdd_pkg::DD_BITS-1:0]      quot
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [mdd_pkg::CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [mdd_pkg::PRICE_BITS-1:0] rem_r, rem_nxt;
  logic [mdd_pkg::DD_BITS-1:0]    quot_r, quot_nxt;
  logic [mdd_pkg::PRICE_BITS:0]   rem_dbl;
  logic [mdd_pkg::PRICE_BITS:0]   rem_sub;
  logic                           take;

  assign rem_dbl = {rem_r, 1'b0};
  assign rem_sub = rem_dbl - {1'b0, peak};
  assign take    = (rem_dbl >= {1'b0, peak});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (start) begin
      quot_nxt = '0;
      priority if (peak == '0) begin
        done_nxt = 1'b1;
      end else if (price == '0) begin
        quot_nxt = mdd_pkg::DD_ONE;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = peak - price;
        cnt_nxt  = mdd_pkg::CNT_BITS'(mdd_pkg::FRAC_BITS);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (take) begin
        rem_nxt  = rem_sub[mdd_pkg::PRICE_BITS-1:0];
        quot_nxt = {quot_r[mdd_pkg::DD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_dbl[mdd_pkg::PRICE_BITS-1:0];
        quot_nxt = {quot_r[mdd_pkg::DD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == mdd_pkg::CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule

// File: rtl/core/max_drawdown_tracker.sv
// ----------------------------------------------------------------------------
// max_drawdown_tracker
// streaming maximum drawdown of a price series with peak and trough indices
// ----------------------------------------------------------------------------
// One price word is taken at a time; in_ready is high only while the
// sequencer is idle. A price that starts a series or sets a new peak goes
// from the compare step straight to the update step that writes the output
// register; any other price first passes through the shared divider, which
// produces one quotient bit per cycle (16 fraction bits). Zero prices and
// zero peaks finish the divider without iterating. The next word can be
// accepted in the cycle after the result is registered. The output register
// frees the input side, so a new word is accepted while the previous result
// waits; a result only stalls the update step.
module max_drawdown_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mdd_pkg::PRICE_BITS-1:0]    in_price,
  input  logic                              in_last_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mdd_pkg::DD_BITS-1:0]       out_max_drawdown,
  output logic [mdd_pkg::INDEX_BITS-1:0]    out_peak_index,
  output logic [mdd_pkg::INDEX_BITS-1:0]    out_trough_index,
  output logic                              out_series_end
);

  mdd_pkg::seq_state_t state_r, state_nxt;

  logic [mdd_pkg::PRICE_BITS-1:0] price_r;
  logic                           last_r;
  logic                           new_peak_r, new_peak_nxt;

  logic [mdd_pkg::PRICE_BITS-1:0] peak_r, peak_nxt;
  logic [mdd_pkg::INDEX_BITS-1:0] peak_pos_r, peak_pos_nxt;
  logic [mdd_pkg::INDEX_BITS-1:0] item_idx_r, item_idx_nxt;
  logic [mdd_pkg::DD_BITS-1:0]    worst_r, worst_nxt;
  logic [mdd_pkg::INDEX_BITS-1:0] worst_peak_r, worst_peak_nxt;
  logic [mdd_pkg::INDEX_BITS-1:0] worst_trough_r, worst_trough_nxt;
  logic                           started_r, started_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [mdd_pkg::DD_BITS-1:0]    out_dd_r;
  logic [mdd_pkg::INDEX_BITS-1:0] out_peak_r;
  logic [mdd_pkg::INDEX_BITS-1:0] out_trough_r;
  logic                           out_end_r;

  logic                           in_fire;
  logic                           out_free;
  logic                           div_start;
  logic                           upd_en;
  mdd_pkg::div_stat_t             div_stat;
  logic [mdd_pkg::DD_BITS-1:0]    div_quot;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  mdd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .peak  (peak_r),
    .price (price_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // next state
  always_comb begin
    state_nxt    = state_r;
    new_peak_nxt = new_peak_r;
    unique case (state_r)
      mdd_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = mdd_pkg::ST_CMP;
      end
      mdd_pkg::ST_CMP: begin
        new_peak_nxt = !started_r || (price_r > peak_r);
        state_nxt    = new_peak_nxt ? mdd_pkg::ST_OUT : mdd_pkg::ST_DIV;
      end
      mdd_pkg::ST_DIV: begin
        if (div_stat.done) state_nxt = mdd_pkg::ST_OUT;
      end
      mdd_pkg::ST_OUT: begin
        if (out_free) state_nxt = mdd_pkg::ST_IDLE;
      end
      default: state_nxt = mdd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    upd_en    = 1'b0;
    unique case (state_r)
      mdd_pkg::ST_IDLE: in_ready  = 1'b1;
      mdd_pkg::ST_CMP:  div_start = started_r && !(price_r > peak_r);
      mdd_pkg::ST_DIV:  upd_en    = 1'b0;
      mdd_pkg::ST_OUT:  upd_en    = out_free;
      default:          upd_en    = 1'b0;
    endcase
  end

  // tracker state update
  always_comb begin
    peak_nxt         = peak_r;
    peak_pos_nxt     = peak_pos_r;
    item_idx_nxt     = item_idx_r;
    worst_nxt        = worst_r;
    worst_peak_nxt   = worst_peak_r;
    worst_trough_nxt = worst_trough_r;
    started_nxt      = started_r;
    if (upd_en) begin
      if (new_peak_r) begin
        peak_nxt     = price_r;
        peak_pos_nxt = item_idx_r;
        started_nxt  = 1'b1;
      end else if (div_quot > worst_r) begin
        worst_nxt        = div_quot;
        worst_peak_nxt   = peak_pos_r;
        worst_trough_nxt = item_idx_r;
      end
      if (item_idx_r != mdd_pkg::INDEX_MAX) item_idx_nxt = item_idx_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (upd_en) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mdd_pkg::ST_IDLE;
      new_peak_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      peak_r         <= '0;
      peak_pos_r     <= '0;
      item_idx_r     <= '0;
      worst_r        <= '0;
      worst_peak_r   <= '0;
      worst_trough_r <= '0;
      started_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      new_peak_r  <= new_peak_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd_en && last_r) begin
        peak_r         <= '0;
        peak_pos_r     <= '0;
        item_idx_r     <= '0;
        worst_r        <= '0;
        worst_peak_r   <= '0;
        worst_trough_r <= '0;
        started_r      <= 1'b0;
      end else begin
        peak_r         <= peak_nxt;
        peak_pos_r     <= peak_pos_nxt;
        item_idx_r     <= item_idx_nxt;
        worst_r        <= worst_nxt;
        worst_peak_r   <= worst_peak_nxt;
        worst_trough_r <= worst_trough_nxt;
        started_r      <= started_nxt;
      end
    end
  end

  // input capture and result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      price_r <= in_price;
      last_r  <= in_last_item;
    end
    if (upd_en) begin
      out_dd_r     <= worst_nxt;
      out_peak_r   <= worst_peak_nxt;
      out_trough_r <= worst_trough_nxt;
      out_end_r    <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_max_drawdown = out_dd_r;
  assign out_peak_index   = out_peak_r;
  assign out_trough_index = out_trough_r;
  assign out_series_end   = out_end_r;

endmodule

// File: rtl/core/mdd_checker.sv
// ----------------------------------------------------------------------------
// mdd_checker
// port-level checks for the drawdown tracker, bound to the top level
// ----------------------------------------------------------------------------
module mdd_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [mdd_pkg::DD_BITS-1:0]       out_max_drawdown,
  input  logic [mdd_pkg::INDEX_BITS-1:0]    out_peak_index,
  input  logic [mdd_pkg::INDEX_BITS-1:0]    out_trough_index
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // one word in flight: busy after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

  // fraction never above one
  a_dd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_max_drawdown <= mdd_pkg::DD_ONE)
    else $error("drawdown above one");

  // no drawdown means no recorded indices
  a_zero_indices: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_max_drawdown == '0 |->
      out_peak_index == '0 && out_trough_index == '0)
    else $error("indices set without drawdown");

  // trough never before its peak, equal once the index saturates
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_max_drawdown != '0 |-> out_trough_index >= out_peak_index)
    else $error("trough before peak");

endmodule

bind max_drawdown_tracker mdd_checker u_mdd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_max_drawdown (out_max_drawdown),
  .out_peak_index   (out_peak_index),
  .out_trough_index (out_trough_index)
);
